// File: sv/restricted_three_body_step_top_assert.svh
// Assertion macros for the restricted three-body step block.
// Used by restricted_three_body_step_top; expects i_clk and i_rst_n in scope.
`ifndef RESTRICTED_THREE_BODY_STEP_TOP_ASSERT_SVH
`define RESTRICTED_THREE_BODY_STEP_TOP_ASSERT_SVH

// same-cycle implication
`define RTBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rtbs_pkg.sv
// Shared types and constants for the restricted three-body step block.
// No dependencies.
package rtbs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QSAT_EXP      = 62;
    localparam logic [63:0] QSAT = 64'd1 << QSAT_EXP;
    localparam logic [63:0] OMEGA_SQ_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam int unsigned MASS_DIV  = 100;
    localparam int unsigned VEL_Y_PIX = 3;
    localparam int unsigned SQRT_STEPS = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_P1_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P2_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P1_COLUMN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P2_COLUMN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANET_ROW = 3'd4;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_PLACE = 1'b1;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_rsp;

endpackage

// File: sv/rtbs_unit.sv
// Shared arithmetic unit: saturating multiply, integer square root and
// fixed-point divide, one operation at a time. Depends on rtbs_pkg.
module rtbs_unit #(
    parameter int FRAC_BITS = rtbs_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rtbs_pkg::t_unit_req i_req,
    input  logic [63:0]        i_a,
    input  logic [63:0]        i_b,
    output rtbs_pkg::t_unit_rsp o_rsp,
    output logic [63:0]        o_res
);
    import rtbs_pkg::*;

    localparam int QSH = QSAT_EXP - FRAC_BITS;

    typedef enum logic [6:0] {
        U_IDLE = 7'b0000001,
        U_MUL0 = 7'b0000010,
        U_MUL1 = 7'b0000100,
        U_MUL2 = 7'b0001000,
        U_SQRT = 7'b0010000,
        U_DIV0 = 7'b0100000,
        U_DIV  = 7'b1000000
    } t_ustate;

    t_ustate             r_state;
    logic [63:0]         r_a;
    logic [63:0]         r_b;
    logic [63:0]         r_pl;
    logic [62:0]         r_ph;
    logic [63:0]         r_x;
    logic [63:0]         r_root;
    logic [63:0]         r_bit;
    logic [63:0]         r_rem;
    logic [QSAT_EXP-1:0] r_sh;
    logic [63:0]         r_q;
    logic [5:0]          r_cnt;
    logic [63:0]         r_res;
    logic                r_done;

    logic [94:0]          w_prod;
    logic [63:0]          w_sq_try;
    logic                 w_sq_ge;
    logic [63:0]          n_x;
    logic [63:0]          n_root;
    logic                 w_ovf;
    logic [63+FRAC_BITS:0] w_nsh;
    logic [64:0]          w_trial;
    logic [64:0]          w_diff;
    logic                 w_div_ge;
    logic [63:0]          n_rem;
    logic [63:0]          n_q;

    always_comb begin
        w_prod   = {r_ph, 32'd0} + {31'd0, r_pl};
        w_sq_try = r_root + r_bit;
        w_sq_ge  = (r_x >= w_sq_try);
        n_x      = w_sq_ge ? (r_x - w_sq_try) : r_x;
        n_root   = w_sq_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
        // quotient would reach 2^62: num*2^F >= den*2^62
        w_ovf    = ({{QSH{1'b0}}, r_a} >= {r_b, {QSH{1'b0}}});
        w_nsh    = {r_a, {FRAC_BITS{1'b0}}};
        w_trial  = {r_rem, r_sh[QSAT_EXP-1]};
        w_div_ge = (w_trial >= {1'b0, r_b});
        w_diff   = w_trial - {1'b0, r_b};
        n_rem    = w_div_ge ? w_diff[63:0] : w_trial[63:0];
        n_q      = {r_q[62:0], w_div_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_a <= i_a;
                        r_b <= i_b;
                        case (i_req.op)
                            OP_MUL:  r_state <= U_MUL0;
                            OP_SQRT: begin
                                r_x     <= i_a;
                                r_root  <= 64'd0;
                                r_bit   <= QSAT;  // top bit pair, 2^62
                                r_cnt   <= 6'(SQRT_STEPS - 1);
                                r_state <= U_SQRT;
                            end
                            OP_DIV:  r_state <= U_DIV0;
                            default: begin
                                r_res  <= 64'd0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                U_MUL0: begin
                    r_pl    <= r_a[31:0] * r_b[31:0];
                    r_state <= U_MUL1;
                end
                U_MUL1: begin
                    r_ph    <= r_a[31:0] * r_b[62:32];
                    r_state <= U_MUL2;
                end
                U_MUL2: begin
                    r_res   <= (w_prod > {31'd0, QSAT}) ? QSAT : w_prod[63:0];
                    r_done  <= 1'b1;
                    r_state <= U_IDLE;
                end
                U_SQRT: begin
                    r_x    <= n_x;
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_res   <= n_root;
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                U_DIV0: begin
                    if (r_a == 64'd0) begin
                        r_res   <= 64'd0;
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else if (w_ovf) begin
                        r_res   <= QSAT;
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else begin
                        r_rem   <= r_a >> QSH;
                        r_sh    <= w_nsh[QSAT_EXP-1:0];
                        r_q     <= 64'd0;
                        r_cnt   <= 6'(QSAT_EXP - 1);
                        r_state <= U_DIV;
                    end
                end
                U_DIV: begin
                    r_rem <= n_rem;
                    r_sh  <= {r_sh[QSAT_EXP-2:0], 1'b0};
                    r_q   <= n_q;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_res   <= n_q;
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_rsp.busy = (r_state != U_IDLE);
    assign o_rsp.done = r_done;
    assign o_res      = r_res;

endmodule

// File: sv/restricted_three_body_step_top.sv
// Restricted three-body step: particle in the rotating frame of two planets.
// Depends on rtbs_pkg, rtbs_unit and restricted_three_body_step_top_assert.svh.
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: pixel_x, pixel_y; tuser: cmd
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: screen_x..accel_z; tuser: impact
//  cfg       in   i_cfg_we                       i_cfg_index, i_cfg_data
//
// Per word rtbs_unit runs, per planet, three multiplies, a 32-step square root
// and two 62-step divides, then ten multiplies unless a planet was hit.
// The first word after reset or a register write first rebuilds the derived
// terms in the same unit.
// tready is high only while idle; a finished result waits in the output
// register and the next word is taken meanwhile.
`include "restricted_three_body_step_top_assert.svh"

module restricted_three_body_step_top #(
    parameter int FRAC_BITS = rtbs_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [31:0]                      i_s_axis_tdata,   // pixel_x, pixel_y
    input  logic                             i_s_axis_tuser,   // cmd
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [127:0]                     o_m_axis_tdata,   // screen_x, screen_y,
                                                               // accel_x, accel_y, accel_z
    output logic                             o_m_axis_tuser,   // impact
    input  logic                             i_cfg_we,
    input  logic [rtbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rtbs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rtbs_pkg::*;

    localparam logic [3:0] CFG_LAST  = 4'd13;
    localparam logic [3:0] GRAV_LAST = 4'd5;
    localparam logic [3:0] TERM_LAST = 4'd9;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CFG    = 7'b0000010,
        ST_PLACE  = 7'b0000100,
        ST_GRAV   = 7'b0001000,
        ST_TERM   = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [15:0] to_pixel(input logic signed [65:0] q);
        logic [65:0] m;
        logic [65:0] p;
        m = q[65] ? 66'(-q) : 66'(q);
        p = m >> FRAC_BITS;
        if (q[65])
            return (p > 66'd32768) ? 16'sh8000 : 16'(-p);
        else
            return (p > 66'd32767) ? 16'sh7FFF : 16'(p);
    endfunction

    // configuration and derived terms
    logic [7:0]   r_rad1, r_rad2;
    logic [11:0]  r_col1, r_col2, r_row;
    logic         r_dirty;
    logic [23:0]  r_m1, r_m2;
    logic [63:0]  r_gm1, r_gm2, r_cog;
    logic [30:0]  r_wsq;
    logic [31:0]  r_wtw;

    // sequencer
    t_state       r_state;
    logic [3:0]   r_pc;
    logic         r_issued;
    logic         r_gp;
    logic         r_hit;
    logic         r_cmd;
    logic signed [15:0] r_px, r_py;
    logic [63:0]  r_t, r_t2, r_s;
    logic [31:0]  r_root;
    logic [63:0]  r_k1, r_k2;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [63:0] r_acc [3];
    logic signed [31:0] r_accq [3];

    logic         r_out_valid;
    logic [127:0] r_out_data;
    logic         r_out_user;

    t_unit_req    w_req;
    t_unit_rsp    w_rsp;
    logic [63:0]  w_a, w_b, w_res;

    logic [24:0]  w_msum;
    logic [11:0]  w_dist;
    logic signed [65:0] w_cog_s, w_rowf, w_col1f, w_col2f;
    logic signed [31:0] w_dx1, w_dx2, w_dx;
    logic [63:0]  w_gm;
    logic [15:0]  w_size;
    logic         w_in;
    logic signed [31:0] w_xterm;
    logic [63:0]  w_kterm;
    logic         w_minus;
    logic [1:0]   w_axis;
    logic [63:0]  w_mag;
    logic signed [63:0] w_term;
    logic signed [31:0] w_accs [3];
    logic signed [31:0] w_vnew [3];
    logic signed [15:0] w_sx, w_sy;
    logic         w_cfg_done;
    logic         w_accept;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        w_msum  = {1'b0, r_m1} + {1'b0, r_m2};
        w_dist  = (r_col2 > r_col1) ? (r_col2 - r_col1) : (r_col1 - r_col2);
        w_cog_s = $signed({2'b00, r_cog});
        w_rowf  = $signed(66'(r_row) << FRAC_BITS);
        w_col1f = $signed(66'(r_col1) << FRAC_BITS);
        w_col2f = $signed(66'(r_col2) << FRAC_BITS);
        w_dx1   = sat32(66'(r_pos[0]) - w_col1f + w_cog_s);
        w_dx2   = sat32(66'(r_pos[0]) - w_col2f + w_cog_s);
        w_dx    = r_gp ? w_dx2 : w_dx1;
        w_gm    = r_gp ? r_gm2 : r_gm1;
        w_size  = r_gp ? (r_rad2 * r_rad2) : (r_rad1 * r_rad1);
        // inside: (S >> F) < r^2 * 2^F
        w_in    = ((r_s >> (2 * FRAC_BITS)) < 64'(w_size));
    end

    // acceleration terms, one multiply each
    always_comb begin
        w_xterm = r_pos[2];
        w_kterm = r_k2;
        w_minus = 1'b1;
        w_axis  = 2'd2;
        case (r_pc)
            4'd0: begin
                w_xterm = r_pos[0]; w_kterm = 64'(r_wsq); w_minus = 1'b0; w_axis = 2'd0;
            end
            4'd1: begin
                w_xterm = r_vel[1]; w_kterm = 64'(r_wtw); w_minus = 1'b0; w_axis = 2'd0;
            end
            4'd2: begin
                w_xterm = w_dx1; w_kterm = r_k1; w_minus = 1'b1; w_axis = 2'd0;
            end
            4'd3: begin
                w_xterm = w_dx2; w_kterm = r_k2; w_minus = 1'b1; w_axis = 2'd0;
            end
            4'd4: begin
                w_xterm = r_pos[1]; w_kterm = 64'(r_wsq); w_minus = 1'b0; w_axis = 2'd1;
            end
            4'd5: begin
                w_xterm = r_vel[0]; w_kterm = 64'(r_wtw); w_minus = 1'b1; w_axis = 2'd1;
            end
            4'd6: begin
                w_xterm = r_pos[1]; w_kterm = r_k1; w_minus = 1'b1; w_axis = 2'd1;
            end
            4'd7: begin
                w_xterm = r_pos[1]; w_kterm = r_k2; w_minus = 1'b1; w_axis = 2'd1;
            end
            4'd8: begin
                w_xterm = r_pos[2]; w_kterm = r_k1; w_minus = 1'b1; w_axis = 2'd2;
            end
            default: begin
                w_xterm = r_pos[2]; w_kterm = r_k2; w_minus = 1'b1; w_axis = 2'd2;
            end
        endcase
        w_mag  = w_res >> FRAC_BITS;
        w_term = (w_xterm[31] ^ w_minus) ? -$signed(w_mag) : $signed(w_mag);
    end

    // operand select for the shared unit
    always_comb begin
        w_req.start = ((r_state == ST_CFG) || (r_state == ST_GRAV) || (r_state == ST_TERM))
                      && !r_issued;
        w_req.op = OP_MUL;
        w_a      = 64'(mag32(w_xterm));
        w_b      = w_kterm;
        if (r_state == ST_CFG) begin
            case (r_pc)
                4'd0:  begin w_req.op = OP_MUL;  w_a = 64'(r_rad1); w_b = 64'(r_rad1); end
                4'd1:  begin w_req.op = OP_MUL;  w_a = r_t;         w_b = 64'(r_rad1); end
                4'd2:  begin w_req.op = OP_MUL;  w_a = 64'(r_rad2); w_b = 64'(r_rad2); end
                4'd3:  begin w_req.op = OP_MUL;  w_a = r_t;         w_b = 64'(r_rad2); end
                4'd4:  begin w_req.op = OP_DIV;  w_a = 64'(r_m1);   w_b = 64'(MASS_DIV); end
                4'd5:  begin w_req.op = OP_DIV;  w_a = 64'(r_m2);   w_b = 64'(MASS_DIV); end
                4'd6:  begin w_req.op = OP_MUL;  w_a = 64'(r_m1);   w_b = 64'(r_col1); end
                4'd7:  begin w_req.op = OP_MUL;  w_a = 64'(r_m2);   w_b = 64'(r_col2); end
                4'd8:  begin w_req.op = OP_DIV;  w_a = r_t + r_t2;  w_b = 64'(w_msum); end
                4'd9:  begin w_req.op = OP_MUL;  w_a = 64'(w_dist); w_b = 64'(MASS_DIV); end
                4'd10: begin w_req.op = OP_MUL;  w_a = r_t;         w_b = 64'(w_dist); end
                4'd11: begin w_req.op = OP_MUL;  w_a = r_t;         w_b = 64'(w_dist); end
                4'd12: begin w_req.op = OP_DIV;  w_a = 64'(w_msum); w_b = r_t; end
                default: begin
                    w_req.op = OP_SQRT; w_a = 64'(r_wsq) << FRAC_BITS; w_b = 64'd0;
                end
            endcase
        end else if (r_state == ST_GRAV) begin
            case (r_pc)
                4'd0: begin w_req.op = OP_MUL; w_a = 64'(mag32(w_dx)); w_b = w_a; end
                4'd1: begin
                    w_req.op = OP_MUL; w_a = 64'(mag32(r_pos[1])); w_b = w_a;
                end
                4'd2: begin
                    w_req.op = OP_MUL; w_a = 64'(mag32(r_pos[2])); w_b = w_a;
                end
                4'd3: begin w_req.op = OP_SQRT; w_a = r_s; w_b = 64'd0; end
                4'd4: begin w_req.op = OP_DIV; w_a = w_gm; w_b = r_s >> FRAC_BITS; end
                default: begin w_req.op = OP_DIV; w_a = r_t; w_b = 64'(r_root); end
            endcase
        end
    end

    rtbs_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_rsp   (w_rsp),
        .o_res   (w_res)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_accs[i] = r_hit ? 32'sd0 : sat32(66'(r_acc[i]));
            w_vnew[i] = sat32(66'(r_vel[i]) + 66'(w_accs[i]));
        end
        w_sx = to_pixel(66'(r_pos[0]) + w_cog_s);
        w_sy = to_pixel(66'(r_pos[1]) + w_rowf);
    end

    assign w_cfg_done = (r_state == ST_CFG) && w_rsp.done && (r_pc == CFG_LAST);

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad1  <= 8'd16;
            r_rad2  <= 8'd8;
            r_col1  <= 12'd100;
            r_col2  <= 12'd300;
            r_row   <= 12'd200;
            r_dirty <= 1'b1;
        end else begin
            if (w_cfg_done)
                r_dirty <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_P1_RADIUS:  begin r_rad1 <= i_cfg_data[7:0]; r_dirty <= 1'b1; end
                    REG_P2_RADIUS:  begin r_rad2 <= i_cfg_data[7:0]; r_dirty <= 1'b1; end
                    REG_P1_COLUMN:  begin r_col1 <= i_cfg_data;      r_dirty <= 1'b1; end
                    REG_P2_COLUMN:  begin r_col2 <= i_cfg_data;      r_dirty <= 1'b1; end
                    REG_PLANET_ROW: begin r_row  <= i_cfg_data;      r_dirty <= 1'b1; end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= 4'd0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= 32'sd0;
                r_vel[i] <= 32'sd0;
            end
        end else begin
            if (i_m_axis_tready)
                r_out_valid <= 1'b0;
            if (w_req.start)
                r_issued <= 1'b1;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd <= i_s_axis_tuser;
                        r_px  <= i_s_axis_tdata[15:0];
                        r_py  <= i_s_axis_tdata[31:16];
                        r_pc  <= 4'd0;
                        r_gp  <= 1'b0;
                        if (r_dirty)
                            r_state <= ST_CFG;
                        else if (i_s_axis_tuser == CMD_PLACE)
                            r_state <= ST_PLACE;
                        else
                            r_state <= ST_GRAV;
                    end
                end
                ST_CFG: begin
                    if (w_rsp.done) begin
                        r_issued <= 1'b0;
                        r_pc     <= r_pc + 4'd1;
                        case (r_pc)
                            4'd1:  r_m1  <= w_res[23:0];
                            4'd3:  r_m2  <= w_res[23:0];
                            4'd4:  r_gm1 <= w_res;
                            4'd5:  r_gm2 <= w_res;
                            4'd7:  r_t2  <= w_res;
                            // no mass at all: centre sits on planet 1
                            4'd8:  r_cog <= (w_msum == 25'd0) ? (64'(r_col1) << FRAC_BITS)
                                                              : w_res;
                            4'd12: begin
                                if (w_dist == 12'd0)
                                    r_wsq <= 31'd0;
                                else if (w_res > OMEGA_SQ_MAX)
                                    r_wsq <= OMEGA_SQ_MAX[30:0];
                                else
                                    r_wsq <= w_res[30:0];
                            end
                            CFG_LAST: begin
                                r_wtw <= {w_res[30:0], 1'b0};
                                r_pc  <= 4'd0;
                                r_state <= (r_cmd == CMD_PLACE) ? ST_PLACE : ST_GRAV;
                            end
                            default: r_t <= w_res;
                        endcase
                    end
                end
                ST_PLACE: begin
                    r_pos[0] <= sat32((66'(r_px) <<< FRAC_BITS) - w_cog_s);
                    r_pos[1] <= sat32((66'(r_py) <<< FRAC_BITS) - w_rowf);
                    r_pos[2] <= 32'sd0;
                    r_vel[0] <= 32'sd0;
                    r_vel[1] <= $signed(32'(VEL_Y_PIX) << FRAC_BITS);
                    r_vel[2] <= 32'sd0;
                    r_pc     <= 4'd0;
                    r_state  <= ST_GRAV;
                end
                ST_GRAV: begin
                    if (w_rsp.done) begin
                        r_issued <= 1'b0;
                        r_pc     <= r_pc + 4'd1;
                        case (r_pc)
                            4'd0: r_s    <= w_res;
                            4'd1: r_s    <= r_s + w_res;
                            4'd2: r_s    <= r_s + w_res;
                            4'd3: r_root <= w_res[31:0];
                            4'd4: r_t    <= w_res;
                            default: begin
                                r_pc <= 4'd0;
                                if (!r_gp) begin
                                    r_k1  <= w_res;
                                    r_hit <= w_in;
                                    r_gp  <= 1'b1;
                                end else begin
                                    r_k2  <= w_res;
                                    r_hit <= r_hit | w_in;
                                    for (int i = 0; i < 3; i++)
                                        r_acc[i] <= 64'sd0;
                                    r_state <= (r_hit | w_in) ? ST_UPDATE : ST_TERM;
                                end
                            end
                        endcase
                    end
                end
                ST_TERM: begin
                    if (w_rsp.done) begin
                        r_issued       <= 1'b0;
                        r_acc[w_axis]  <= r_acc[w_axis] + w_term;
                        r_pc           <= r_pc + 4'd1;
                        if (r_pc == TERM_LAST)
                            r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    for (int i = 0; i < 3; i++)
                        r_accq[i] <= w_accs[i];
                    if (r_hit) begin
                        for (int i = 0; i < 3; i++)
                            r_vel[i] <= 32'sd0;
                    end else if (r_cmd == CMD_TICK) begin
                        for (int i = 0; i < 3; i++) begin
                            r_vel[i] <= w_vnew[i];
                            r_pos[i] <= sat32(66'(r_pos[i]) + 66'(w_vnew[i]));
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_accq[2], r_accq[1], r_accq[0], w_sy, w_sx};
                        r_out_user  <= r_hit;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    `RTBS_ASSERT_IMP(a_start_idle_unit, w_req.start, !w_rsp.busy, "unit started while busy")
    `RTBS_ASSERT_IMP(a_done_issued, w_rsp.done, r_issued, "unit result with no request")
    `RTBS_ASSERT_NXT(a_busy_after_accept, w_accept, !o_s_axis_tready, "ready after accept")

endmodule

// File: tb/tb_top.sv
// Testbench for restricted_three_body_step_top: a directed table, then random place/tick runs.
// Uses its own orbit predictor and a scoreboard of expected words.
// Depends on rtbs_pkg and the RTL only.
`timescale 1ns/1ps
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rtbs_pkg::*;

    localparam int F = FRAC_BITS_DEF;
    localparam int N_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 262;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic               hit;
    } orbit_res_t;

    typedef struct {
        logic        cmd;
        shortint     px;
        shortint     py;
        bit          typed;
        orbit_res_t  res;
    } stim_row_t;

    logic i_clk, i_rst_n;
    logic i_s_axis_tvalid, i_s_axis_tuser;
    logic [31:0] i_s_axis_tdata;
    logic o_s_axis_tready;
    logic o_m_axis_tvalid, o_m_axis_tuser, i_m_axis_tready;
    logic [127:0] o_m_axis_tdata;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    restricted_three_body_step_top dut (.*);

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // ---------------- orbit predictor ----------------
    bit [63:0] r1_q, r2_q, c1_q, c2_q, row_q;
    bit [63:0] size1, size2, gm1, gm2, w_sq, w_tw;
    longint    cog_x, cog_y, off1, off2;
    int        pos[3], vel[3];

    function automatic longint sat32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic bit [63:0] mag(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic bit [63:0] isqrt(bit [63:0] s);
        bit [63:0] res = 0, bt = 64'd1 << 62;
        while (bt > s) bt >>= 2;
        while (bt != 0) begin
            if (s >= res + bt) begin
                s -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // floor(num * 2^F / den), saturated
    function automatic bit [63:0] qdiv(bit [63:0] num, bit [63:0] den);
        bit [63:0] q, r;
        if (num == 0) return 0;
        if (den == 0) return QSAT;
        q = num / den;
        if (q >= (QSAT >> F)) return QSAT;
        r = num % den;
        for (int i = 0; i < F; i++) begin
            q <<= 1;
            r <<= 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic longint mulq(longint a, bit [63:0] k);
        bit [63:0] m, p;
        m = mag(a);
        if (k != 0 && m > QSAT / k) p = QSAT; else p = m * k;
        p >>= F;
        return a < 0 ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint to_pixel(longint q);
        longint p;
        p = q < 0 ? -longint'(mag(q) >> F) : longint'(64'(q) >> F);
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p;
    endfunction

    function automatic void rebuild_terms();
        bit [63:0] m1, m2, msum, d, w;
        m1 = r1_q * r1_q * r1_q;
        m2 = r2_q * r2_q * r2_q;
        msum = m1 + m2;
        size1 = (r1_q * r1_q) << F;
        size2 = (r2_q * r2_q) << F;
        gm1 = (m1 << F) / MASS_DIV;
        gm2 = (m2 << F) / MASS_DIV;
        if (msum != 0) cog_x = longint'(((m1 * c1_q + m2 * c2_q) << F) / msum);
        else cog_x = longint'(c1_q << F);
        cog_y = longint'(row_q << F);
        off1 = longint'(c1_q << F) - cog_x;
        off2 = longint'(c2_q << F) - cog_x;
        d = c2_q > c1_q ? c2_q - c1_q : c1_q - c2_q;
        if (d == 0) begin
            w = 0;
        end else begin
            w = (msum << F) / (MASS_DIV * d * d * d);
            if (w > OMEGA_SQ_MAX) w = OMEGA_SQ_MAX;
        end
        w_sq = w;
        w_tw = 2 * isqrt(w << F);
    endfunction

    function automatic bit pull(longint dx, longint dy, longint dz, bit [63:0] gm,
                                bit [63:0] size, output bit [63:0] k);
        bit [63:0] ax, ay, az, s, ds;
        ax = mag(dx); ay = mag(dy); az = mag(dz);
        s = ax * ax + ay * ay + az * az;
        ds = s >> F;
        k = qdiv(qdiv(gm, ds), isqrt(s));
        return ds < size;
    endfunction

    function automatic bit accel(output int acc[3]);
        longint lx, ly, lz, dx1, dx2;
        bit [63:0] k1, k2;
        bit in1, in2;
        lx = pos[0]; ly = pos[1]; lz = pos[2];
        dx1 = sat32(lx - off1);
        dx2 = sat32(lx - off2);
        in1 = pull(dx1, ly, lz, gm1, size1, k1);
        in2 = pull(dx2, ly, lz, gm2, size2, k2);
        if (in1 || in2) begin
            acc = '{0, 0, 0};
            vel = '{0, 0, 0};
            return 1'b1;
        end
        acc[0] = int'(sat32(mulq(lx, w_sq) + mulq(vel[1], w_tw) - mulq(dx1, k1)
                            - mulq(dx2, k2)));
        acc[1] = int'(sat32(mulq(ly, w_sq) - mulq(vel[0], w_tw) - mulq(ly, k1)
                            - mulq(ly, k2)));
        acc[2] = int'(sat32(-mulq(lz, k1) - mulq(lz, k2)));
        return 1'b0;
    endfunction

    function automatic orbit_res_t orbit_step(logic cmd, shortint px, shortint py);
        orbit_res_t r;
        int acc[3];
        bit hit;
        if (cmd == CMD_PLACE) begin
            pos[0] = int'(sat32(longint'(px) * (64'sd1 << F) - cog_x));
            pos[1] = int'(sat32(longint'(py) * (64'sd1 << F) - cog_y));
            pos[2] = 0;
            vel = '{0, VEL_Y_PIX << F, 0};
            hit = accel(acc);
        end else begin
            hit = accel(acc);
            for (int i = 0; i < 3; i++) vel[i] = int'(sat32(longint'(vel[i]) + acc[i]));
            for (int i = 0; i < 3; i++) pos[i] = int'(sat32(longint'(pos[i]) + vel[i]));
        end
        r.sx = 16'(to_pixel(longint'(pos[0]) + cog_x));
        r.sy = 16'(to_pixel(longint'(pos[1]) + cog_y));
        r.ax = acc[0]; r.ay = acc[1]; r.az = acc[2];
        r.hit = hit;
        return r;
    endfunction

    // ---------------- scoreboard ----------------
    orbit_res_t pending_words[$];
    int mismatches = 0;
    int words_seen = 0;
    int impacts_seen = 0;
    bit quiet = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            orbit_res_t got, want;
            got.sx = o_m_axis_tdata[15:0];
            got.sy = o_m_axis_tdata[31:16];
            got.ax = o_m_axis_tdata[63:32];
            got.ay = o_m_axis_tdata[95:64];
            got.az = o_m_axis_tdata[127:96];
            got.hit = o_m_axis_tuser;
            words_seen++;
            if (got.hit) impacts_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word %p", got);
            end else begin
                want = pending_words.pop_front();
                if (got.sx !== want.sx || got.sy !== want.sy || got.ax !== want.ax ||
                    got.ay !== want.ay || got.az !== want.az || got.hit !== want.hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d mismatch: exp %p got %p", words_seen, want, got);
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off so the block backs up
    initial begin
        bit held;
        held = 0;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && words_seen >= 300) begin
                held = 1;
                i_m_axis_tready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- drivers ----------------
    task automatic send_word(logic cmd, shortint px, shortint py, bit typed,
                             orbit_res_t typed_res);
        orbit_res_t r;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {py, px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = orbit_step(cmd, px, py);
        pending_words.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_P1_RADIUS:  r1_q = val & 8'hFF;
            REG_P2_RADIUS:  r2_q = val & 8'hFF;
            REG_P1_COLUMN:  c1_q = val;
            REG_P2_COLUMN:  c2_q = val;
            REG_PLANET_ROW: row_q = val;
            default: return;
        endcase
        rebuild_terms();
    endtask

    // planet setups: reset values, extremes, massless planet, no mass at all,
    // columns swapped, columns equal
    logic [CFG_DATA_W-1:0] setups[N_PHASES][5] = '{
        '{16, 8, 100, 300, 200},
        '{1, 1, 0, 4095, 0},
        '{12'h1FF, 255, 2000, 2010, 4095},
        '{40, 0, 500, 900, 300},
        '{0, 0, 700, 1200, 2500},
        '{20, 10, 800, 400, 100},
        '{30, 12, 600, 600, 50}
    };

    orbit_res_t hit_p1 = '{16'sd100, 16'sd200, 0, 0, 0, 1'b1};
    orbit_res_t hit_p2 = '{16'sd300, 16'sd200, 0, 0, 0, 1'b1};
    orbit_res_t none = '{0, 0, 0, 0, 0, 1'b0};

    // directed table; impacts at the reset planet centres are known by eye
    stim_row_t directed[] = '{
        '{CMD_TICK,  0, 0, 0, none},
        '{CMD_TICK,  0, 0, 0, none},
        '{CMD_PLACE, 100, 200, 1, hit_p1},
        '{CMD_TICK,  0, 0, 1, hit_p1},
        '{CMD_PLACE, 300, 200, 1, hit_p2},
        '{CMD_PLACE, 32767, 32767, 0, none},
        '{CMD_TICK,  0, 0, 0, none},
        '{CMD_PLACE, -32768, -32768, 0, none},
        '{CMD_TICK,  0, 0, 0, none},
        '{CMD_PLACE, 0, 0, 0, none},
        '{CMD_PLACE, -1, -1, 0, none},
        '{CMD_TICK,  -1, -1, 0, none},
        '{CMD_PLACE, 122, 200, 0, none},
        '{CMD_PLACE, 200, 260, 0, none},
        '{CMD_TICK,  0, 0, 0, none},
        '{CMD_TICK,  0, 0, 0, none},
        '{CMD_TICK,  0, 0, 0, none},
        '{CMD_PLACE, 117, 200, 0, none},
        '{CMD_TICK,  0, 0, 0, none},
        '{CMD_PLACE, 21845, -21846, 0, none}
    };

    initial begin
        int sent, run_len;
        shortint px, py;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tuser = CMD_TICK;
        i_s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        r1_q = 16; r2_q = 8; c1_q = 100; c2_q = 300; row_q = 200;
        pos = '{0, 0, 0};
        vel = '{0, 0, 0};
        rebuild_terms();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_word(directed[i].cmd, directed[i].px, directed[i].py,
                      directed[i].typed, directed[i].res);
        drain();
        write_reg(3'd5, 12'hABC);   // unmapped index, ignored
        write_reg(3'd7, 12'hFFF);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            write_reg(REG_P1_RADIUS, setups[ph][0]);
            write_reg(REG_P2_RADIUS, setups[ph][1]);
            write_reg(REG_P1_COLUMN, setups[ph][2]);
            write_reg(REG_P2_COLUMN, setups[ph][3]);
            write_reg(REG_PLANET_ROW, setups[ph][4]);
            if (ph == N_PHASES - 1) quiet = 1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: anywhere in the 16-bit field
                    px = shortint'($urandom);
                    py = shortint'($urandom);
                end else begin
                    px = shortint'((cog_x >>> F) + $urandom_range(0, 800) - 400);
                    py = shortint'((cog_y >>> F) + $urandom_range(0, 800) - 400);
                end
                send_word(CMD_PLACE, px, py, 0, none);
                sent++;
                run_len = $urandom_range(3, 40);
                for (int t = 0; t < run_len && sent < ITEMS_PER_PHASE; t++) begin
                    // pixel fields are don't-care on a tick; toggle them anyway
                    send_word(($urandom_range(0, 19) == 0) ? CMD_PLACE : CMD_TICK,
                              shortint'($urandom), shortint'($urandom), 0, none);
                    sent++;
                end
            end
        end
        drain();
        repeat (450) @(posedge i_clk);
        $display("Covered %0d output words (%0d impacts) over %0d planet setups,",
                 words_seen, impacts_seen, N_PHASES + 1);
        $display("with random stalls on both sides and one long output hold-off.");
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, pending_words.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("timeout with %0d words outstanding", pending_words.size());
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/rtbs_pkg.sv
sv/rtbs_unit.sv
sv/restricted_three_body_step_top.sv
tb/tb_top.sv
